>>> hdl/pidfd_pkg.sv
package pidfd_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int SAT_W = (DATA_WIDTH > 32) ? 32 : ((DATA_WIDTH < 16) ? 16 : DATA_WIDTH);

  localparam int ACC_W  = 50;
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DVD_W  = 57;
  localparam int DVS_W  = 33;
  localparam int CNT_W  = $clog2(DVD_W);
  localparam int ADDR_W = 5;
  localparam int RAW_W  = DVD_W + 1;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
  localparam logic signed [RAW_W-1:0] RAW_HI = RAW_W'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);
  localparam logic signed [RAW_W-1:0] RAW_LO = -RAW_HI - RAW_W'(1);

  typedef enum logic [2:0] {
    REG_KP    = 3'd0,
    REG_KI    = 3'd1,
    REG_KD    = 3'd2,
    REG_LIMIT = 3'd3,
    REG_TAU   = 3'd4,
    REG_PI    = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_I,
    ST_I_HI,
    ST_I_LO,
    ST_I_ACC,
    ST_DIV_RAW,
    ST_DIV_ALPHA,
    ST_F_MUL,
    ST_F_ADD,
    ST_D_MUL,
    ST_D_ACC,
    ST_SUM
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [ACC_W-1:0] apply_sign(input logic [ACC_W-2:0] m,
                                                         input logic neg);
    logic signed [ACC_W-1:0] s;
    s = $signed({1'b0, m});
    return neg ? -s : s;
  endfunction

  function automatic logic signed [31:0] sat_acc(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
    return c[31:0];
  endfunction

endpackage

>>> hdl/pidfd_mul.sv
module pidfd_mul (
  input  logic                          clk,
  input  logic [pidfd_pkg::MUL_W-1:0]   a,
  input  logic [pidfd_pkg::MUL_W-1:0]   b,
  output logic [pidfd_pkg::PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

>>> hdl/pidfd_div.sv
module pidfd_div (
  input  logic                clk,
  input  logic                rst,
  input  pidfd_pkg::div_req_t req,
  output pidfd_pkg::div_rsp_t rsp
);

  logic                          busy;
  logic                          done;
  logic [pidfd_pkg::CNT_W-1:0]   cnt;
  logic [pidfd_pkg::DVS_W-1:0]   rem;
  logic [pidfd_pkg::DVS_W-1:0]   dvs;
  logic [pidfd_pkg::DVD_W-1:0]   dq;
  logic [pidfd_pkg::DVS_W:0]     rem_sh;
  logic [pidfd_pkg::DVS_W:0]     trial;
  logic                          ge;

  // One quotient bit per cycle; dq shifts the dividend out and the quotient in.
  always_comb begin
    rem_sh = {rem, dq[pidfd_pkg::DVD_W-1]};
    trial  = rem_sh - {1'b0, dvs};
    ge     = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == pidfd_pkg::CNT_W'(pidfd_pkg::DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dq  <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= ge ? trial[pidfd_pkg::DVS_W-1:0] : rem_sh[pidfd_pkg::DVS_W-1:0];
      dq  <= {dq[pidfd_pkg::DVD_W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dq;

endmodule

>>> hdl/pid_filtered_derivative.sv
// Fixed-point PID controller with clamped integrator and low-pass derivative.
// Registers are written over the APB port (byte address 4*index); the user
// must write them only while idle, as the block does not enforce it. The input
// channel (in_valid/in_stall) carries action, error and time_step; a clear
// action zeroes the integrator and yields no result. The output channel
// (out_valid/out_stall) carries one saturated drive per control step.
// Without the derivative term a step skips the divider. With it, the
// bit-serial divider runs twice, first for the raw derivative and then for
// the filter coefficient. All products go through one registered 33x33
// multiplier. One item is processed at a time; in_stall is high while a
// step is in progress. A finished drive waits in the output register while
// the receiver stalls, and the next item can already be accepted; that step
// then holds before writing its own result until the register is free.
// Reset clears the configuration registers, the integrator, the previous
// error and the filter state.
module pid_filtered_derivative (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pidfd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic signed [31:0]            error,
  input  logic [23:0]                   time_step,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            drive
);

  logic signed [31:0] proportional_gain;
  logic signed [31:0] integral_gain;
  logic signed [31:0] derivative_gain;
  logic [30:0]        integral_limit;
  logic [31:0]        derivative_filter_time;
  logic               pi_only;

  logic signed [31:0] integrator;
  logic signed [31:0] previous_error;
  logic signed [31:0] filtered_derivative;

  pidfd_pkg::state_t  state, state_next;
  logic signed [31:0] e;
  logic [23:0]        dt;
  logic signed [pidfd_pkg::ACC_W-1:0] acc_sum;
  logic [31:0]        m_lo;
  logic [55:0]        a_part;
  logic signed [31:0] raw;
  logic [24:0]        alpha;

  logic [pidfd_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic [pidfd_pkg::PROD_W-1:0] prod;
  pidfd_pkg::div_req_t div_req;
  pidfd_pkg::div_rsp_t div_rsp;

  logic accept, cfg_wr, i_en, d_en;
  logic signed [32:0] err_diff, f_diff;
  logic [32:0] err_diff_mag, f_diff_mag;
  logic [56:0] i_sum;
  logic signed [pidfd_pkg::ACC_W-1:0] i_acc, i_clamp, lim;
  logic signed [pidfd_pkg::RAW_W-1:0] raw_full;
  logic signed [34:0] filt;

  pidfd_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));
  pidfd_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      proportional_gain      <= '0;
      integral_gain          <= '0;
      derivative_gain        <= '0;
      integral_limit         <= '0;
      derivative_filter_time <= '0;
      pi_only                <= 1'b0;
    end else if (cfg_wr) begin
      case (pidfd_pkg::reg_idx_t'(paddr[4:2]))
        pidfd_pkg::REG_KP:    proportional_gain      <= pwdata;
        pidfd_pkg::REG_KI:    integral_gain          <= pwdata;
        pidfd_pkg::REG_KD:    derivative_gain        <= pwdata;
        pidfd_pkg::REG_LIMIT: integral_limit         <= pwdata[30:0];
        pidfd_pkg::REG_TAU:   derivative_filter_time <= pwdata;
        pidfd_pkg::REG_PI:    pi_only                <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (pidfd_pkg::reg_idx_t'(paddr[4:2]))
      pidfd_pkg::REG_KP:    prdata = proportional_gain;
      pidfd_pkg::REG_KI:    prdata = integral_gain;
      pidfd_pkg::REG_KD:    prdata = derivative_gain;
      pidfd_pkg::REG_LIMIT: prdata = {1'b0, integral_limit};
      pidfd_pkg::REG_TAU:   prdata = derivative_filter_time;
      pidfd_pkg::REG_PI:    prdata = {31'd0, pi_only};
      default:              prdata = '0;
    endcase
  end

  // Datapath helpers.
  assign accept = in_valid && !in_stall;
  assign i_en   = (integral_gain != '0) && (dt != '0);
  assign d_en   = !pi_only && (derivative_gain != '0) && (dt != '0);

  always_comb begin
    err_diff     = 33'(e) - 33'(previous_error);
    err_diff_mag = err_diff[32] ? 33'(-err_diff) : 33'(err_diff);
    f_diff       = 33'(raw) - 33'(filtered_derivative);
    f_diff_mag   = f_diff[32] ? 33'(-f_diff) : 33'(f_diff);
    // Exact (|e*ki| * dt) >> 40 from the two 32-bit halves of |e*ki|.
    i_sum        = 57'(a_part) + 57'(prod[55:32]);
    i_acc        = 50'(integrator) +
                   pidfd_pkg::apply_sign(i_sum[56:8], e[31] ^ integral_gain[31]);
    lim          = 50'($signed({1'b0, integral_limit}));
    i_clamp      = (i_acc > lim) ? lim : ((i_acc < -lim) ? -lim : i_acc);
    raw_full     = $signed({1'b0, div_rsp.quotient});
    if (err_diff[32]) raw_full = -raw_full;
    if (raw_full > pidfd_pkg::RAW_HI) raw_full = pidfd_pkg::RAW_HI;
    if (raw_full < pidfd_pkg::RAW_LO) raw_full = pidfd_pkg::RAW_LO;
    filt         = 35'(filtered_derivative) +
                   (f_diff[32] ? -35'($signed({1'b0, prod[57:24]}))
                               :  35'($signed({1'b0, prod[57:24]})));
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) state <= pidfd_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next       = state;
    in_stall         = (state != pidfd_pkg::ST_IDLE);
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = {err_diff_mag, 24'd0};
    div_req.divisor  = 33'(dt);
    case (state)
      pidfd_pkg::ST_IDLE: begin
        if (accept && !action) state_next = pidfd_pkg::ST_MUL_P;
      end
      pidfd_pkg::ST_MUL_P: begin
        mul_a      = {1'b0, pidfd_pkg::mag32(e)};
        mul_b      = {1'b0, pidfd_pkg::mag32(proportional_gain)};
        state_next = pidfd_pkg::ST_MUL_I;
      end
      pidfd_pkg::ST_MUL_I: begin
        mul_a      = {1'b0, pidfd_pkg::mag32(e)};
        mul_b      = {1'b0, pidfd_pkg::mag32(integral_gain)};
        state_next = pidfd_pkg::ST_I_HI;
      end
      pidfd_pkg::ST_I_HI: begin
        mul_a      = {1'b0, prod[63:32]};
        mul_b      = 33'(dt);
        state_next = pidfd_pkg::ST_I_LO;
      end
      pidfd_pkg::ST_I_LO: begin
        mul_a      = {1'b0, m_lo};
        mul_b      = 33'(dt);
        state_next = pidfd_pkg::ST_I_ACC;
      end
      pidfd_pkg::ST_I_ACC: begin
        div_req.start = d_en;
        state_next    = d_en ? pidfd_pkg::ST_DIV_RAW : pidfd_pkg::ST_SUM;
      end
      pidfd_pkg::ST_DIV_RAW: begin
        div_req.dividend = 57'({dt, 24'd0});
        div_req.divisor  = {1'b0, derivative_filter_time} + 33'(dt);
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          state_next    = pidfd_pkg::ST_DIV_ALPHA;
        end
      end
      pidfd_pkg::ST_DIV_ALPHA: begin
        if (div_rsp.done) state_next = pidfd_pkg::ST_F_MUL;
      end
      pidfd_pkg::ST_F_MUL: begin
        mul_a      = f_diff_mag;
        mul_b      = 33'(alpha);
        state_next = pidfd_pkg::ST_F_ADD;
      end
      pidfd_pkg::ST_F_ADD: state_next = pidfd_pkg::ST_D_MUL;
      pidfd_pkg::ST_D_MUL: begin
        mul_a      = {1'b0, pidfd_pkg::mag32(derivative_gain)};
        mul_b      = {1'b0, pidfd_pkg::mag32(filtered_derivative)};
        state_next = pidfd_pkg::ST_D_ACC;
      end
      pidfd_pkg::ST_D_ACC: state_next = pidfd_pkg::ST_SUM;
      pidfd_pkg::ST_SUM: begin
        if (!out_valid || !out_stall) state_next = pidfd_pkg::ST_IDLE;
      end
      default: state_next = pidfd_pkg::ST_IDLE;
    endcase
  end

  // Controller state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      integrator          <= '0;
      previous_error      <= '0;
      filtered_derivative <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (state == pidfd_pkg::ST_SUM && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall)                             out_valid <= 1'b0;
      case (state)
        pidfd_pkg::ST_IDLE: begin
          if (accept && action) integrator <= '0;
        end
        pidfd_pkg::ST_I_ACC: begin
          if (i_en) integrator <= i_clamp[31:0];
        end
        pidfd_pkg::ST_F_ADD: begin
          filtered_derivative <= filt[31:0];
          previous_error      <= e;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      pidfd_pkg::ST_IDLE: begin
        if (accept) begin
          e  <= error;
          dt <= time_step;
        end
      end
      pidfd_pkg::ST_MUL_I: begin
        acc_sum <= pidfd_pkg::apply_sign(prod[pidfd_pkg::ACC_W+14:16],
                                         e[31] ^ proportional_gain[31]);
      end
      pidfd_pkg::ST_I_HI:  m_lo   <= prod[31:0];
      pidfd_pkg::ST_I_ACC: begin
        if (i_en) acc_sum <= acc_sum + i_clamp;
      end
      pidfd_pkg::ST_I_LO:  a_part <= prod[55:0];
      pidfd_pkg::ST_DIV_RAW: begin
        if (div_rsp.done) raw <= raw_full[31:0];
      end
      pidfd_pkg::ST_DIV_ALPHA: begin
        if (div_rsp.done) alpha <= div_rsp.quotient[24:0];
      end
      pidfd_pkg::ST_D_ACC: begin
        acc_sum <= acc_sum + pidfd_pkg::apply_sign(prod[pidfd_pkg::ACC_W+14:16],
                     derivative_gain[31] ^ filtered_derivative[31]);
      end
      pidfd_pkg::ST_SUM: begin
        if (!out_valid || !out_stall) drive <= pidfd_pkg::sat_acc(acc_sum);
      end
      default: ;
    endcase
  end

  // A clear action leaves the integrator at zero and produces no step.
  assert property (@(posedge clk) disable iff (rst)
    accept && action |=> integrator == '0 && state == pidfd_pkg::ST_IDLE)
    else $error("clear action did not clear the integrator");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == pidfd_pkg::ST_DIV_RAW || state == pidfd_pkg::ST_DIV_ALPHA))
    else $error("divider finished outside a division state");

  // A new result is only loaded from the final summing state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == pidfd_pkg::ST_SUM)
    else $error("result appeared outside the summing state");

endmodule

>>> bench/tb_top.sv
module tb_top;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 200;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [pidfd_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid, in_stall, action;
  logic signed [31:0] error;
  logic [23:0] time_step;
  logic out_valid, out_stall;
  logic signed [31:0] drive;

  pid_filtered_derivative dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .action(action),
    .error(error), .time_step(time_step),
    .out_valid(out_valid), .out_stall(out_stall), .drive(drive)
  );

  // Controller copy: registers and state.
  longint kp, ki, kd, lim;
  longint unsigned tau;
  bit pi_mode;
  longint integ, prev_err, filt_der;

  logic [31:0] drive_expected[$];
  int errors = 0;
  int steps_sent = 0;
  int clears_sent = 0;
  int drives_checked = 0;
  int cycles = 0;
  bit gap_on = 1;
  bit stall_on = 1;
  int hold_req = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint signed_of(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp_word(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (pidfd_pkg::SAT_W - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint scaled_product(longint a, longint b, int sh);
    longint unsigned m;
    m = (magn(a) * magn(b)) >> sh;
    return signed_of(m, (a < 0) != (b < 0));
  endfunction

  function automatic longint integ_increment(longint e, longint k, longint unsigned dt);
    longint unsigned m, a, b, r;
    m = magn(e) * magn(k);
    a = (m >> 32) * dt;
    b = (m & 64'hFFFF_FFFF) * dt;
    r = (a >> 8) + ((((a & 64'hFF) << 32) + b) >> 40);
    return signed_of(r, (e < 0) != (k < 0));
  endfunction

  // Advances the controller copy by one item; returns 1 when a drive results.
  function automatic bit predict_drive(bit act, logic signed [31:0] err_in,
                                       logic [23:0] dt_in, output logic [31:0] result);
    longint e, p, i, d, acc, diff, raw, filt;
    longint unsigned dt, q, alpha;
    e = err_in;
    dt = dt_in;
    i = 0;
    d = 0;
    result = '0;
    if (act) begin
      integ = 0;
      return 0;
    end
    p = scaled_product(e, kp, 16);
    if (ki != 0 && dt != 0) begin
      acc = integ + integ_increment(e, ki, dt);
      if (acc > lim) acc = lim;
      if (acc < -lim) acc = -lim;
      integ = acc;
      i = acc;
    end
    if (!pi_mode && kd != 0 && dt != 0) begin
      diff = e - prev_err;
      q = (magn(diff) << 24) / dt;
      raw = clamp_word(signed_of(q, diff < 0));
      alpha = (dt << 24) / (tau + dt);
      filt = filt_der + scaled_product(raw - filt_der, longint'(alpha), 24);
      prev_err = e;
      filt_der = filt;
      d = scaled_product(kd, filt, 16);
    end
    result = 32'(clamp_word(p + i + d));
    return 1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic reg_write(pidfd_pkg::reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= pidfd_pkg::ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      pidfd_pkg::REG_KP: kp = longint'($signed(value));
      pidfd_pkg::REG_KI: ki = longint'($signed(value));
      pidfd_pkg::REG_KD: kd = longint'($signed(value));
      pidfd_pkg::REG_LIMIT: lim = value[30:0];
      pidfd_pkg::REG_TAU: tau = value;
      pidfd_pkg::REG_PI: pi_mode = value[0];
      default: ;
    endcase
  endtask

  task automatic set_gains(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                           logic [31:0] l, logic [31:0] t, bit pio);
    reg_write(pidfd_pkg::REG_KP, p);
    reg_write(pidfd_pkg::REG_KI, i);
    reg_write(pidfd_pkg::REG_KD, d);
    reg_write(pidfd_pkg::REG_LIMIT, l);
    reg_write(pidfd_pkg::REG_TAU, t);
    reg_write(pidfd_pkg::REG_PI, {31'b0, pio});
  endtask

  // Offers one item and returns once the transfer has happened.
  task automatic send_item(bit act, logic [31:0] e, logic [23:0] dt);
    int gap;
    logic [31:0] result;
    gap = gap_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1;
    action <= act;
    error <= e;
    time_step <= dt;
    do @(posedge clk); while (in_stall);
    if (predict_drive(act, e, dt, result)) begin
      drive_expected.push_back(result);
      steps_sent++;
    end else begin
      clears_sent++;
    end
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid <= 0;
    while (drive_expected.size() != 0) @(posedge clk);
    // A clear may still be in flight after the last drive.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_random();
    int pick;
    logic [31:0] e;
    logic [23:0] dt;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: e = $urandom;
      1: e = 32'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
      2: e = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: e = 32'($signed($urandom_range(0, 2 * 65536 * 200)) - 65536 * 200);
    endcase
    case ($urandom_range(0, 3))
      0: dt = 24'($urandom);
      1: dt = 24'($urandom_range(1, 40));
      2: dt = 24'($urandom_range(1, 24'h4000));
      default: dt = 24'($urandom_range(24'h1000, 24'h10_0000));
    endcase
    if (pick < 5) dt = 0;
    send_item(pick >= 95, e, dt);
  endtask

  // Receiver: each result draws its own stall; a hold request forces a long one.
  initial begin
    int n;
    out_stall = 1;
    @(negedge clk);
    while (rst) @(negedge clk);
    out_stall <= 0;
    forever begin
      n = stall_on ? $urandom_range(0, 13) : 0;
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
      end
      if (n > 0) begin
        @(negedge clk);
        out_stall <= 1;
        repeat (n - 1) @(negedge clk);
        @(negedge clk);
        out_stall <= 0;
      end
      do @(posedge clk); while (!out_valid);
      if (drive_expected.size() == 0) begin
        report_mismatch("unexpected drive", drive, 'x);
      end else begin
        logic [31:0] want;
        want = drive_expected.pop_front();
        if (drive !== want) report_mismatch("drive", drive, want);
        drives_checked++;
      end
    end
  end

  task automatic test_directed();
    set_gains(32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'h0010_0000, 32'h0010_0000, 0);
    send_item(0, 32'h7FFF_FFFF, 24'hFF_FFFF);
    send_item(0, 32'h8000_0000, 24'hFF_FFFF);
    send_item(0, 32'h8000_0000, 24'h00_0001);
    send_item(0, 32'h7FFF_FFFF, 24'h00_0001);
    send_item(0, 32'h0001_0000, 24'h00_0000);
    send_item(1, 32'hFFFF_FFFF, 24'hFF_FFFF);
    send_item(0, 32'h0000_0000, 24'h01_0000);
    send_item(0, 32'hFFFF_0000, 24'h00_1000);
    go_quiet();
    // Integral off, derivative at extremes, zero filter time.
    set_gains(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 0);
    send_item(0, 32'h0000_0001, 24'h00_0001);
    send_item(0, 32'h8000_0000, 24'h00_0001);
    send_item(0, 32'h7FFF_FFFF, 24'h80_0000);
    send_item(0, 32'h0001_0000, 24'h00_0000);
    go_quiet();
    // Derivative gain zero (PI-only flag clear), limit zero and largest filter time.
    set_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 0);
    send_item(0, 32'h7FFF_FFFF, 24'hFF_FFFF);
    send_item(0, 32'h1234_5678, 24'h00_0100);
    go_quiet();
    reg_write(pidfd_pkg::REG_PI, 32'h1);
    reg_write(pidfd_pkg::REG_KD, 32'h0001_0000);
    reg_write(pidfd_pkg::REG_LIMIT, 32'h7FFF_FFFF);
    send_item(0, 32'h7FFF_FFFF, 24'hFF_FFFF);
    send_item(0, 32'h8000_0000, 24'hFF_FFFF);
    send_item(1, 32'h0, 24'h0);
    send_item(0, 32'h0000_1000, 24'h00_0010);
    go_quiet();
  endtask

  task automatic test_random_phases();
    logic [31:0] p, i, d, l, t;
    for (int ph = 0; ph < 8; ph++) begin
      gap_on = (ph % 3) != 2;
      stall_on = (ph % 4) != 3;
      p = (ph == 0) ? 32'h7FFF_FFFF : (ph == 1 ? 32'h8000_0000 : $urandom);
      i = (ph == 2) ? 32'h7FFF_FFFF : (ph == 3 ? 32'h8000_0000 : $urandom);
      d = (ph == 4) ? 32'h7FFF_FFFF : (ph == 5 ? 32'h8000_0000 : $urandom);
      l = (ph == 6) ? 32'h0 : (ph == 7 ? 32'h7FFF_FFFF : $urandom);
      t = (ph == 1) ? 32'h0 : (ph == 2 ? 32'hFFFF_FFFF : $urandom_range(0, 32'h0400_0000));
      if (ph >= 6) begin
        p = $urandom_range(0, 32'h0004_0000);
        i = $urandom_range(0, 32'h0010_0000);
        d = $urandom_range(0, 32'h0000_4000);
      end
      set_gains(p, i, d, l, t, ph == 3);
      repeat (125) send_random();
      go_quiet();
    end
    gap_on = 1;
    stall_on = 1;
  endtask

  task automatic test_backpressure();
    set_gains(32'h0001_0000, 32'h0000_4000, 32'h0000_1000, 32'h0100_0000, 32'h0000_2000, 0);
    gap_on = 0;
    hold_req = 600;
    repeat (30) send_random();
    gap_on = 1;
    go_quiet();
  endtask

  initial begin
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    in_valid = 0;
    action = 0;
    error = '0;
    time_step = '0;
    kp = 0; ki = 0; kd = 0; lim = 0; tau = 0; pi_mode = 0;
    integ = 0; prev_err = 0; filt_der = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    test_random_phases();
    test_backpressure();
    $display("covered %0d control steps and %0d integrator clears, %0d drives checked",
             steps_sent, clears_sent, drives_checked);
    $display("gain, limit, filter time and PI-only settings swept, including extremes");
    if (errors == 0 && drive_expected.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/pidfd_pkg.sv
hdl/pidfd_mul.sv
hdl/pidfd_div.sv
hdl/pid_filtered_derivative.sv
bench/tb_top.sv
